### design/r2fft_pkg.sv
// shared types, constants and twiddle table for the radix-2 frame fft
`default_nettype none

package r2fft_pkg;

	// frame geometry
	localparam int LOG_MAX    = 10;
	localparam int MAX_POINTS = 1 << LOG_MAX;
	localparam int IDX_W      = LOG_MAX;
	localparam int SAMPLE_W   = 16;
	localparam int BIN_W      = 32;

	// twiddle table covers one quarter wave of a full circle of TW_N points
	localparam int TW_N = MAX_POINTS;
	localparam int TW_Q = TW_N / 4;
	localparam int TW_H = TW_N / 2;
	localparam int TW_IDX_W = LOG_MAX - 1;
	localparam longint TWOPI_Q40 = 64'sd6908435304728;

	// input word
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_real;
		logic signed [SAMPLE_W-1:0] sample_imag;
	} sample_t;

	// output word
	typedef struct packed {
		logic signed [BIN_W-1:0] bin_real;
		logic signed [BIN_W-1:0] bin_imag;
		logic [IDX_W-1:0]        bin_index;
		logic                    valid_res;
		logic                    last;
	} bin_t;

	typedef logic signed [16:0] tw_tab_t [0:TW_Q];

	typedef struct packed {
		logic signed [16:0] wr;
		logic signed [16:0] wi;
	} tw_t;

	// cos or sin of 2*pi*a/TW_N in q15 from a q30 taylor series
	function automatic logic signed [16:0] taylor_q15(input int a, input bit want_sin);
		longint x;
		longint x2;
		longint term;
		longint sum;
		longint p;
		x = ((TWOPI_Q40 * longint'(a)) >>> LOG_MAX) + 64'sd512;
		x = x >>> 10;
		x2 = (x * x) >>> 30;
		term = want_sin ? x : (64'sd1 <<< 30);
		sum = term;
		// series denominators (2n)(2n+1) for sine, (2n-1)(2n) for cosine
		for (int n = 1; n <= 7; n++) begin
			p = -((term * x2) >>> 30);
			case (n)
				1: term = want_sin ? p / 64'sd6   : p / 64'sd2;
				2: term = want_sin ? p / 64'sd20  : p / 64'sd12;
				3: term = want_sin ? p / 64'sd42  : p / 64'sd30;
				4: term = want_sin ? p / 64'sd72  : p / 64'sd56;
				5: term = want_sin ? p / 64'sd110 : p / 64'sd90;
				6: term = want_sin ? p / 64'sd156 : p / 64'sd132;
				7: term = want_sin ? p / 64'sd210 : p / 64'sd182;
				default: term = 64'sd0;
			endcase
			sum = sum + term;
		end
		return 17'((sum + 64'sd16384) >>> 15);
	endfunction

	// quarter wave table, built at elaboration
	function automatic tw_tab_t tw_build();
		tw_tab_t t;
		for (int i = 0; i <= TW_Q; i++) begin
			if (8 * i <= TW_N) begin
				t[i] = taylor_q15(i, 1'b0);
			end else begin
				t[i] = taylor_q15(TW_Q - i, 1'b1);
			end
		end
		return t;
	endfunction

	localparam tw_tab_t TW_TAB = tw_build();

	// twiddle for index k in the lower half circle
	function automatic tw_t twiddle(input logic [TW_IDX_W-1:0] k);
		tw_t w;
		logic [TW_IDX_W:0] kx;
		kx = {1'b0, k};
		if (k == '0) begin
			w.wr = 17'sd32768;
			w.wi = 17'sd0;
		end else if (kx <= (TW_IDX_W+1)'(TW_Q)) begin
			w.wr = TW_TAB[k];
			w.wi = TW_TAB[TW_IDX_W'((TW_IDX_W+1)'(TW_Q) - kx)];
		end else begin
			w.wr = -TW_TAB[TW_IDX_W'((TW_IDX_W+1)'(TW_H) - kx)];
			w.wi = TW_TAB[TW_IDX_W'(kx - (TW_IDX_W+1)'(TW_Q))];
		end
		return w;
	endfunction

endpackage

`default_nettype wire

### design/radix2_fft_frame.sv
// radix-2 frame fft: sample loading, in-place transform and bin readout
//
// Samples are collected into a frame of 2^log_size points (1 to 10); each
// accepted sample returns the bin of the previous frame at the same index
// (zeros with valid_res low during the first frame). While a frame loads the
// block takes no new sample until the registered read of the work memory
// for the last one has reached the output register. When the last sample of
// a frame arrives the block stops accepting and runs the transform: a
// bit-reversed copy, then log2(N) butterfly passes, and for inverse frames a
// scaling pass, all paced by the single read and single write port of the
// work memory (two reads and two writes per butterfly). Size and direction
// are taken at the first sample of a frame.
`default_nettype none

module radix2_fft_frame (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              sample_valid,
	output logic                   sample_ready,
	input  wire r2fft_pkg::sample_t sample,
	output logic                   bin_valid,
	input  wire logic              bin_ready,
	output r2fft_pkg::bin_t        bin,
	input  wire logic              cfg_write,
	input  wire logic              cfg_index,
	input  wire logic [3:0]        cfg_data
);

	localparam int LM = r2fft_pkg::LOG_MAX;
	localparam int IW = r2fft_pkg::IDX_W;
	localparam int BW = LM - 1;

	localparam logic CFG_INVERSE  = 1'b0;
	localparam logic CFG_LOG_SIZE = 1'b1;

	localparam logic [1:0] ST_LOAD  = 2'd0;
	localparam logic [1:0] ST_COPY  = 2'd1;
	localparam logic [1:0] ST_BFLY  = 2'd2;
	localparam logic [1:0] ST_SCALE = 2'd3;

	// memories
	logic [31:0] load_mem [0:r2fft_pkg::MAX_POINTS-1];
	logic [63:0] work_mem [0:r2fft_pkg::MAX_POINTS-1];
	logic [31:0] load_rd_q;
	logic [63:0] work_rd_q;

	// control state
	logic [1:0]    state_q;
	logic          inverse_q;
	logic [3:0]    log_size_q;
	logic [IW-1:0] count_q;
	logic          have_result_q;
	logic [IW:0]   prev_len_q;
	logic [3:0]    frame_log_q;
	logic          frame_inv_q;
	logic [IW-1:0] ctr_q;
	logic          done_q;
	logic [3:0]    st_q;
	logic [BW-1:0] bcnt_q;
	logic          sub_q;

	// pipeline valids and payload
	logic          out_s1_v;
	logic          out_s1_hit;
	logic          out_s1_last;
	logic [IW-1:0] out_s1_idx;
	logic          out_valid_q;
	r2fft_pkg::bin_t out_q;
	logic          cp_s1_v;
	logic [IW-1:0] cp_s1_addr;
	logic          sc_s1_v;
	logic [IW-1:0] sc_s1_addr;
	logic          bf_s1_v, bf_s2_v, bf_s3_v, bf_s4_v;
	logic [IW-1:0] ua_s1, va_s1, ua_s2, va_s2, ua_s3, va_s3, va_s4;
	logic [63:0]   u_s1, u_s2, u_s3, d_s4;
	logic signed [16:0] wr_s1, wi_s1;
	logic signed [48:0] rr_s2, ii_s2, ri_s2, ir_s2;
	logic signed [34:0] pr_s3, pi_s3;

	// saturate a 36-bit sum to 32 bits
	function automatic logic [31:0] sat32(input logic signed [35:0] x);
		if (x > 36'sd2147483647) begin
			return 32'h7fff_ffff;
		end else if (x < -36'sd2147483648) begin
			return 32'h8000_0000;
		end
		return x[31:0];
	endfunction

	// reverse all index bits
	function automatic logic [IW-1:0] rev_bits(input logic [IW-1:0] x);
		logic [IW-1:0] r;
		for (int b = 0; b < IW; b++) begin
			r[b] = x[IW-1-b];
		end
		return r;
	endfunction

	// frame size for the sample at hand
	logic [3:0]    eff_log, cur_log;
	logic [IW:0]   cur_len;
	logic          accept;
	logic          frame_end;
	always_comb begin
		if (log_size_q == 4'd0) begin
			eff_log = 4'd1;
		end else if (log_size_q > 4'(LM)) begin
			eff_log = 4'(LM);
		end else begin
			eff_log = log_size_q;
		end
		cur_log = (count_q == '0) ? eff_log : frame_log_q;
		cur_len = (IW+1)'(1) << cur_log;
	end

	assign sample_ready = (state_q == ST_LOAD) && !out_s1_v && (!out_valid_q || bin_ready);
	assign accept = sample_valid && sample_ready;
	assign frame_end = ({1'b0, count_q} == cur_len - (IW+1)'(1));

	// butterfly addressing for the current pass
	logic [IW:0]   h_full;
	logic [BW-1:0] j_mask;
	logic [BW-1:0] j_val;
	logic [IW-1:0] ua, va;
	logic [BW-1:0] k_idx;
	logic [IW:0]   half_m1;
	logic          bf_last;
	logic          pipe_busy;
	always_comb begin
		h_full  = (IW+1)'(1) << (st_q - 4'd1);
		j_mask  = BW'(h_full - (IW+1)'(1));
		j_val   = bcnt_q & j_mask;
		ua      = {bcnt_q & ~j_mask, 1'b0} | {1'b0, j_val};
		va      = ua | IW'(h_full);
		k_idx   = BW'({1'b0, j_val} << (4'(LM) - st_q));
		half_m1 = ((IW+1)'(1) << (frame_log_q - 4'd1)) - (IW+1)'(1);
		bf_last = (bcnt_q == BW'(half_m1));
		pipe_busy = cp_s1_v | sc_s1_v | bf_s1_v | bf_s2_v | bf_s3_v | bf_s4_v;
	end

	// work memory read address
	logic [IW-1:0] work_raddr;
	always_comb begin
		case (state_q)
			ST_LOAD:  work_raddr = count_q;
			ST_BFLY:  work_raddr = sub_q ? va : ua;
			default:  work_raddr = ctr_q;
		endcase
	end

	// butterfly sums and scaled values
	logic signed [49:0] sum_r, sum_i;
	logic signed [35:0] a_r, a_i, s_r, s_i;
	logic signed [32:0] sc_re, sc_im, sc_rnd;
	always_comb begin
		sum_r = rr_s2 - ii_s2 + 50'sd16384;
		sum_i = ri_s2 + ir_s2 + 50'sd16384;
		a_r = $signed(u_s3[63:32]) + pr_s3;
		a_i = $signed(u_s3[31:0]) + pi_s3;
		s_r = $signed(u_s3[63:32]) - pr_s3;
		s_i = $signed(u_s3[31:0]) - pi_s3;
		sc_rnd = 33'sd1 <<< (frame_log_q - 4'd1);
		sc_re = ($signed({work_rd_q[63], work_rd_q[63:32]}) + sc_rnd) >>> frame_log_q;
		sc_im = ($signed({work_rd_q[31], work_rd_q[31:0]}) + sc_rnd) >>> frame_log_q;
	end

	// work memory write port
	logic          work_we;
	logic [IW-1:0] work_waddr;
	logic [63:0]   work_wdata;
	always_comb begin
		work_we    = 1'b0;
		work_waddr = cp_s1_addr;
		work_wdata = {{16{load_rd_q[31]}}, load_rd_q[31:16],
			{16{load_rd_q[15]}}, load_rd_q[15:0]};
		if (cp_s1_v) begin
			work_we = 1'b1;
		end else if (sc_s1_v) begin
			work_we    = 1'b1;
			work_waddr = sc_s1_addr;
			work_wdata = {sc_re[31:0], sc_im[31:0]};
		end else if (bf_s3_v) begin
			work_we    = 1'b1;
			work_waddr = ua_s3;
			work_wdata = {sat32(a_r), sat32(a_i)};
		end else if (bf_s4_v) begin
			work_we    = 1'b1;
			work_waddr = va_s4;
			work_wdata = d_s4;
		end
	end

	// memory ports
	always_ff @(posedge clk) begin
		if (accept) begin
			load_mem[count_q] <= {sample.sample_real, sample.sample_imag};
		end
		load_rd_q <= load_mem[ctr_q];
		if (work_we) begin
			work_mem[work_waddr] <= work_wdata;
		end
		work_rd_q <= work_mem[work_raddr];
	end

	// sequencer and valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_LOAD;
			inverse_q     <= 1'b0;
			log_size_q    <= 4'd10;
			count_q       <= '0;
			have_result_q <= 1'b0;
			prev_len_q    <= '0;
			frame_log_q   <= 4'(LM);
			frame_inv_q   <= 1'b0;
			ctr_q         <= '0;
			done_q        <= 1'b0;
			st_q          <= 4'd1;
			bcnt_q        <= '0;
			sub_q         <= 1'b0;
			out_s1_v      <= 1'b0;
			out_valid_q   <= 1'b0;
			cp_s1_v       <= 1'b0;
			sc_s1_v       <= 1'b0;
			bf_s1_v       <= 1'b0;
			bf_s2_v       <= 1'b0;
			bf_s3_v       <= 1'b0;
			bf_s4_v       <= 1'b0;
		end else begin
			// register writes
			if (cfg_write) begin
				case (cfg_index)
					CFG_INVERSE:  inverse_q  <= cfg_data[0];
					CFG_LOG_SIZE: log_size_q <= cfg_data;
					default: ;
				endcase
			end

			// result word handoff
			out_s1_v <= accept;
			if (out_s1_v) begin
				out_valid_q <= 1'b1;
			end else if (bin_ready) begin
				out_valid_q <= 1'b0;
			end

			// issue pulses for copy, scale and butterfly pipelines
			cp_s1_v <= (state_q == ST_COPY) && !done_q;
			sc_s1_v <= (state_q == ST_SCALE) && !done_q;
			bf_s1_v <= (state_q == ST_BFLY) && !done_q && sub_q;
			bf_s2_v <= bf_s1_v;
			bf_s3_v <= bf_s2_v;
			bf_s4_v <= bf_s3_v;

			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (count_q == '0) begin
							frame_log_q <= eff_log;
							frame_inv_q <= inverse_q;
						end
						if (frame_end) begin
							count_q       <= '0;
							have_result_q <= 1'b1;
							prev_len_q    <= cur_len;
							state_q       <= ST_COPY;
							ctr_q         <= '0;
							done_q        <= 1'b0;
						end else begin
							count_q <= count_q + IW'(1);
						end
					end
				end
				ST_COPY: begin
					if (!done_q) begin
						if ({1'b0, ctr_q} == prev_len_q - (IW+1)'(1)) begin
							done_q <= 1'b1;
						end else begin
							ctr_q <= ctr_q + IW'(1);
						end
					end else if (!pipe_busy) begin
						state_q <= ST_BFLY;
						st_q    <= 4'd1;
						bcnt_q  <= '0;
						sub_q   <= 1'b0;
						done_q  <= 1'b0;
					end
				end
				ST_BFLY: begin
					if (!done_q) begin
						sub_q <= !sub_q;
						if (sub_q) begin
							if (bf_last) begin
								done_q <= 1'b1;
							end else begin
								bcnt_q <= bcnt_q + BW'(1);
							end
						end
					end else if (!pipe_busy) begin
						done_q <= 1'b0;
						bcnt_q <= '0;
						if (st_q == frame_log_q) begin
							ctr_q   <= '0;
							state_q <= frame_inv_q ? ST_SCALE : ST_LOAD;
						end else begin
							st_q <= st_q + 4'd1;
						end
					end
				end
				ST_SCALE: begin
					if (!done_q) begin
						if ({1'b0, ctr_q} == prev_len_q - (IW+1)'(1)) begin
							done_q <= 1'b1;
						end else begin
							ctr_q <= ctr_q + IW'(1);
						end
					end else if (!pipe_busy) begin
						done_q  <= 1'b0;
						state_q <= ST_LOAD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// datapath registers
	r2fft_pkg::tw_t tw_cur;
	always_comb begin
		tw_cur = r2fft_pkg::twiddle(k_idx);
	end

	always_ff @(posedge clk) begin
		// result metadata at acceptance
		out_s1_hit  <= have_result_q && ({1'b0, count_q} < prev_len_q);
		out_s1_last <= ({1'b0, count_q} == prev_len_q - (IW+1)'(1));
		out_s1_idx  <= count_q;
		if (out_s1_v) begin
			out_q.bin_real  <= out_s1_hit ? $signed(work_rd_q[63:32]) : '0;
			out_q.bin_imag  <= out_s1_hit ? $signed(work_rd_q[31:0]) : '0;
			out_q.bin_index <= out_s1_hit ? out_s1_idx : '0;
			out_q.valid_res <= out_s1_hit;
			out_q.last      <= out_s1_hit && out_s1_last;
		end

		// copy into bit-reversed place
		cp_s1_addr <= rev_bits(ctr_q) >> (4'(LM) - frame_log_q);
		sc_s1_addr <= ctr_q;

		// butterfly: capture u and twiddle
		ua_s1 <= ua;
		va_s1 <= va;
		u_s1  <= work_rd_q;
		wr_s1 <= tw_cur.wr;
		wi_s1 <= frame_inv_q ? -tw_cur.wi : tw_cur.wi;

		// butterfly: products with v
		rr_s2 <= wr_s1 * $signed(work_rd_q[63:32]);
		ii_s2 <= wi_s1 * $signed(work_rd_q[31:0]);
		ri_s2 <= wr_s1 * $signed(work_rd_q[31:0]);
		ir_s2 <= wi_s1 * $signed(work_rd_q[63:32]);
		u_s2  <= u_s1;
		ua_s2 <= ua_s1;
		va_s2 <= va_s1;

		// butterfly: rounded product
		pr_s3 <= 35'(sum_r >>> 15);
		pi_s3 <= 35'(sum_i >>> 15);
		u_s3  <= u_s2;
		ua_s3 <= ua_s2;
		va_s3 <= va_s2;

		// butterfly: difference waits for the write port
		d_s4  <= {sat32(s_r), sat32(s_i)};
		va_s4 <= va_s3;
	end

	assign bin_valid = out_valid_q;
	assign bin       = out_q;

	// one writer on the work memory port at a time
	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cp_s1_v, sc_s1_v, bf_s3_v, bf_s4_v}))
		else $error("work memory write port driven twice");

	// a finished frame starts the transform
	a_frame_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && frame_end |=> state_q == ST_COPY)
		else $error("frame end did not start the transform");

	// pending read data always finds the output register free
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_s1_v |-> !out_valid_q)
		else $error("result word overwritten");

endmodule

`default_nettype wire
